[design/normal_map_texel_transform_macros.svh]
// ----------------------------------------------------------------------------
// Normal-map texel transform assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef NORMAL_MAP_TEXEL_TRANSFORM_MACROS_SVH
`define NORMAL_MAP_TEXEL_TRANSFORM_MACROS_SVH

// same-cycle implication, sampled on clk, idle during reset
`define NMT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("normal map transform check failed");

// next-cycle implication, sampled on clk, idle during reset
`define NMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("normal map transform check failed");

`endif

[design/nmt_pkg.sv]
// ----------------------------------------------------------------------------
// Normal-map texel transform package
// Transaction types, register indexes and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nmt_pkg;

  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_W         = 16;
  localparam int REG_W         = 24;
  localparam int LANES         = 3;
  localparam int LANE_X        = 0;
  localparam int LANE_Y        = 1;
  localparam int LANE_Z        = 2;
  // 4095^2 : near-axis threshold against 4096^2
  localparam logic [23:0] NEAR_K = 24'd16769025;
  localparam logic signed [REG_W-1:0] REG_ONE = 24'sd65536;

  typedef enum logic [1:0] {
    CFG_SCALE_X = 2'd0,
    CFG_SKEW_X  = 2'd1,
    CFG_SKEW_Y  = 2'd2,
    CFG_SCALE_Y = 2'd3
  } nmt_cfg_e;

  typedef struct packed {
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
    logic       span_end;
  } nmt_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    zero_vector;
    logic                    span_end_out;
  } nmt_out_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic near_axis;
    logic zero_vec;
    logic txy_zero;
    logic span_end;
  } nmt_side_t;

endpackage

[design/normal_map_texel_transform.sv]
// ----------------------------------------------------------------------------
// Normal-map texel transform
// Takes one texel per clock while the output is not stalled and returns one
// Q1.14 unit normal per texel, in order. A seven-stage front end decodes
// the bytes, applies the 2x2 inverse transform and forms exact ratio terms;
// a row of OUT_FRAC_BITS + 1 root cells, one result bit each, follows, and
// an output register holds the result. When out_ready is low with a result
// waiting, the whole pipeline holds and in_ready drops. The user must write
// the matrix registers through the cfg port only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module normal_map_texel_transform #(
  parameter int OUT_FRAC_BITS = nmt_pkg::OUT_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  nmt_pkg::nmt_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nmt_pkg::nmt_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [nmt_pkg::REG_W-1:0]   cfg_wdata
);
  import nmt_pkg::*;

  localparam int RES_W = 2*OUT_FRAC_BITS+87;
  localparam int N_W   = OUT_FRAC_BITS+1;
  localparam int CELLS = OUT_FRAC_BITS+1;
  localparam int EXT_W = OUT_FRAC_BITS+17;

  logic en;
  logic signed [REG_W-1:0] m_scale_x_r, m_skew_x_r, m_skew_y_r, m_scale_y_r;

  logic                        ch_v    [0:CELLS];
  nmt_side_t                   ch_side [0:CELLS];
  logic [LANES-1:0][RES_W-1:0] ch_r    [0:CELLS];
  logic [LANES-1:0][RES_W-1:0] ch_d    [0:CELLS];
  logic [LANES-1:0][RES_W-1:0] ch_den  [0:CELLS];
  logic [LANES-1:0][N_W-1:0]   ch_n    [0:CELLS];

  logic     out_valid_r;
  nmt_out_t out_data_r, out_nxt;
  logic [EXT_W-1:0] mag_x, mag_y, mag_z, one_ext, sx, sy, sz, so;
  nmt_side_t last_side;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_scale_x_r <= REG_ONE;
      m_skew_x_r  <= '0;
      m_skew_y_r  <= '0;
      m_scale_y_r <= REG_ONE;
    end else if (cfg_we) begin
      unique case (nmt_cfg_e'(cfg_index))
        CFG_SCALE_X: m_scale_x_r <= cfg_wdata;
        CFG_SKEW_X:  m_skew_x_r  <= cfg_wdata;
        CFG_SKEW_Y:  m_skew_y_r  <= cfg_wdata;
        CFG_SCALE_Y: m_scale_y_r <= cfg_wdata;
        default:     m_scale_x_r <= m_scale_x_r;
      endcase
    end
  end

  nmt_front #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .m_scale_x (m_scale_x_r),
    .m_skew_x  (m_skew_x_r),
    .m_skew_y  (m_skew_y_r),
    .m_scale_y (m_scale_y_r),
    .out_v     (ch_v[0]),
    .out_side  (ch_side[0]),
    .out_r     (ch_r[0]),
    .out_d     (ch_d[0]),
    .out_den   (ch_den[0])
  );

  assign ch_n[0] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    nmt_cell #(.OUT_FRAC_BITS(OUT_FRAC_BITS), .BIT(OUT_FRAC_BITS - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (ch_v[k]),
      .in_side  (ch_side[k]),
      .in_r     (ch_r[k]),
      .in_d     (ch_d[k]),
      .in_den   (ch_den[k]),
      .in_n     (ch_n[k]),
      .out_v    (ch_v[k+1]),
      .out_side (ch_side[k+1]),
      .out_r    (ch_r[k+1]),
      .out_d    (ch_d[k+1]),
      .out_den  (ch_den[k+1]),
      .out_n    (ch_n[k+1])
    );
  end

  always_comb begin
    last_side = ch_side[CELLS];
    mag_x     = EXT_W'(ch_n[CELLS][LANE_X]);
    mag_y     = EXT_W'(ch_n[CELLS][LANE_Y]);
    mag_z     = EXT_W'(ch_n[CELLS][LANE_Z]);
    one_ext   = EXT_W'(1) << OUT_FRAC_BITS;
    sx        = last_side.neg_x ? -mag_x : mag_x;
    sy        = last_side.neg_y ? -mag_y : mag_y;
    sz        = last_side.neg_z ? -mag_z : mag_z;
    so        = last_side.neg_z ? -one_ext : one_ext;
    out_nxt.zero_vector  = 1'b0;
    out_nxt.span_end_out = last_side.span_end;
    priority if (last_side.zero_vec) begin
      out_nxt.normal_x    = '0;
      out_nxt.normal_y    = '0;
      out_nxt.normal_z    = '0;
      out_nxt.zero_vector = 1'b1;
    end else if (last_side.near_axis) begin
      out_nxt.normal_x = '0;
      out_nxt.normal_y = '0;
      out_nxt.normal_z = so[OUT_W-1:0];
    end else if (last_side.txy_zero) begin
      out_nxt.normal_x = '0;
      out_nxt.normal_y = '0;
      out_nxt.normal_z = sz[OUT_W-1:0];
    end else begin
      out_nxt.normal_x = sx[OUT_W-1:0];
      out_nxt.normal_y = sy[OUT_W-1:0];
      out_nxt.normal_z = sz[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ch_v[CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/nmt_front.sv]
// ----------------------------------------------------------------------------
// Normal-map texel front end
// Decodes the texel, forms squares, the 2x2 transform and the exact
// numerator and denominator of each ratio, and seeds the root cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmt_front #(
  parameter int OUT_FRAC_BITS = nmt_pkg::OUT_FRAC_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  nmt_pkg::nmt_in_t                             in_data,
  input  logic signed [nmt_pkg::REG_W-1:0]             m_scale_x,
  input  logic signed [nmt_pkg::REG_W-1:0]             m_skew_x,
  input  logic signed [nmt_pkg::REG_W-1:0]             m_skew_y,
  input  logic signed [nmt_pkg::REG_W-1:0]             m_scale_y,
  output logic                                         out_v,
  output nmt_pkg::nmt_side_t                           out_side,
  output logic [nmt_pkg::LANES-1:0][2*OUT_FRAC_BITS+86:0] out_r,
  output logic [nmt_pkg::LANES-1:0][2*OUT_FRAC_BITS+86:0] out_d,
  output logic [nmt_pkg::LANES-1:0][2*OUT_FRAC_BITS+86:0] out_den
);
  import nmt_pkg::*;

  localparam int RES_W = 2*OUT_FRAC_BITS+87;
  localparam int SH    = 2*OUT_FRAC_BITS+2;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  nmt_in_t   in1_r;
  nmt_side_t side2_r, side3_r, side4_r, side5_r, side6_r, side7_r;
  nmt_side_t side3_nxt, side5_nxt;

  // stage 2
  logic signed [9:0]  dx, dy, dz;
  logic signed [19:0] sqx, sqy, sqz;
  logic [14:0]        x2_r, y2_r, z2_r;
  logic signed [34:0] tx_nxt, ty_nxt, tx_r, ty_r;
  // stage 3
  logic signed [34:0] ntx, nty;
  logic [31:0]        ax, ay;
  logic [15:0]        len2_nxt, s_nxt, len2_3_r, s3_r, len2_4_r, len2_5_r, len2_6_r;
  logic [14:0]        z2_3_r, z2_4_r, z2_5_r, z2_6_r;
  logic [63:0]        tx2_r, ty2_r;
  logic [39:0]        near_l, near_rhs;
  // stage 4
  logic [64:0]        tsum_r;
  logic [47:0]        plo_x_r, phi_x_r, plo_y_r, phi_y_r;
  // stage 5
  logic [79:0]        numx_r, numy_r, numx6_r, numy6_r;
  logic [47:0]        pd_lo_r;
  logic [48:0]        pd_hi_r;
  // stage 6
  logic [80:0]        den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_comb begin
    dx     = $signed({2'b00, in1_r.red_byte}) - 10'sd127;
    dy     = $signed({2'b00, in1_r.green_byte}) - 10'sd127;
    dz     = $signed({2'b00, in1_r.blue_byte}) - 10'sd127;
    sqx    = dx * dx;
    sqy    = dy * dy;
    sqz    = dz * dz;
    tx_nxt = m_scale_x * dx + m_skew_x * dy;
    ty_nxt = m_skew_y * dx + m_scale_y * dy;
  end

  always_comb begin
    ntx      = -tx_r;
    nty      = -ty_r;
    ax       = tx_r[34] ? ntx[31:0] : tx_r[31:0];
    ay       = ty_r[34] ? nty[31:0] : ty_r[31:0];
    len2_nxt = 16'(x2_r) + 16'(y2_r) + 16'(z2_r);
    s_nxt    = 16'(x2_r) + 16'(y2_r);
    near_l   = 40'({z2_r, 24'd0});
    near_rhs = 40'(NEAR_K) * 40'(len2_nxt);
    side3_nxt           = side2_r;
    side3_nxt.neg_x     = tx_r[34];
    side3_nxt.neg_y     = ty_r[34];
    side3_nxt.near_axis = near_l >= near_rhs;
    side3_nxt.zero_vec  = len2_nxt == 16'd0;
    side5_nxt           = side4_r;
    side5_nxt.txy_zero  = tsum_r == 65'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in1_r <= in_data;
      // stage 2
      x2_r  <= sqx[14:0];
      y2_r  <= sqy[14:0];
      z2_r  <= sqz[14:0];
      tx_r  <= tx_nxt;
      ty_r  <= ty_nxt;
      side2_r <= '{neg_x: 1'b0, neg_y: 1'b0, neg_z: dz[9], near_axis: 1'b0,
                   zero_vec: 1'b0, txy_zero: 1'b0, span_end: in1_r.span_end};
      // stage 3
      len2_3_r <= len2_nxt;
      s3_r     <= s_nxt;
      z2_3_r   <= z2_r;
      tx2_r    <= 64'(ax) * 64'(ax);
      ty2_r    <= 64'(ay) * 64'(ay);
      side3_r  <= side3_nxt;
      // stage 4
      tsum_r   <= 65'(tx2_r) + 65'(ty2_r);
      plo_x_r  <= 48'(tx2_r[31:0]) * 48'(s3_r);
      phi_x_r  <= 48'(tx2_r[63:32]) * 48'(s3_r);
      plo_y_r  <= 48'(ty2_r[31:0]) * 48'(s3_r);
      phi_y_r  <= 48'(ty2_r[63:32]) * 48'(s3_r);
      len2_4_r <= len2_3_r;
      z2_4_r   <= z2_3_r;
      side4_r  <= side3_r;
      // stage 5
      numx_r   <= {phi_x_r, 32'd0} + 80'(plo_x_r);
      numy_r   <= {phi_y_r, 32'd0} + 80'(plo_y_r);
      pd_lo_r  <= 48'(tsum_r[31:0]) * 48'(len2_4_r);
      pd_hi_r  <= 49'(tsum_r[64:32]) * 49'(len2_4_r);
      len2_5_r <= len2_4_r;
      z2_5_r   <= z2_4_r;
      side5_r  <= side5_nxt;
      // stage 6
      den_r    <= {pd_hi_r, 32'd0} + 81'(pd_lo_r);
      numx6_r  <= numx_r;
      numy6_r  <= numy_r;
      len2_6_r <= len2_5_r;
      z2_6_r   <= z2_5_r;
      side6_r  <= side5_r;
      // stage 7: seed residual and running product
      out_r[LANE_X]   <= (RES_W'(numx6_r) << SH) - RES_W'(den_r);
      out_r[LANE_Y]   <= (RES_W'(numy6_r) << SH) - RES_W'(den_r);
      out_r[LANE_Z]   <= (RES_W'(z2_6_r) << SH) - RES_W'(len2_6_r);
      out_d[LANE_X]   <= -RES_W'(den_r);
      out_d[LANE_Y]   <= -RES_W'(den_r);
      out_d[LANE_Z]   <= -RES_W'(len2_6_r);
      out_den[LANE_X] <= RES_W'(den_r);
      out_den[LANE_Y] <= RES_W'(den_r);
      out_den[LANE_Z] <= RES_W'(len2_6_r);
      side7_r  <= side6_r;
    end
  end

  assign out_v    = v7_r;
  assign out_side = side7_r;

endmodule

[design/nmt_cell.sv]
// ----------------------------------------------------------------------------
// Normal-map root cell
// Resolves one result bit of the rounded square root of num/den on all
// three lanes and hands residual, running product and partial root on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmt_cell #(
  parameter int OUT_FRAC_BITS = nmt_pkg::OUT_FRAC_BITS,
  parameter int BIT           = 0
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic                                            in_v,
  input  nmt_pkg::nmt_side_t                              in_side,
  input  logic [nmt_pkg::LANES-1:0][2*OUT_FRAC_BITS+86:0] in_r,
  input  logic [nmt_pkg::LANES-1:0][2*OUT_FRAC_BITS+86:0] in_d,
  input  logic [nmt_pkg::LANES-1:0][2*OUT_FRAC_BITS+86:0] in_den,
  input  logic [nmt_pkg::LANES-1:0][OUT_FRAC_BITS:0]      in_n,
  output logic                                            out_v,
  output nmt_pkg::nmt_side_t                              out_side,
  output logic [nmt_pkg::LANES-1:0][2*OUT_FRAC_BITS+86:0] out_r,
  output logic [nmt_pkg::LANES-1:0][2*OUT_FRAC_BITS+86:0] out_d,
  output logic [nmt_pkg::LANES-1:0][2*OUT_FRAC_BITS+86:0] out_den,
  output logic [nmt_pkg::LANES-1:0][OUT_FRAC_BITS:0]      out_n
);
  import nmt_pkg::*;

  localparam int RES_W = 2*OUT_FRAC_BITS+87;
  localparam int N_W   = OUT_FRAC_BITS+1;

  logic [LANES-1:0][RES_W-1:0] trial, diff, r_nxt, d_nxt;
  logic [LANES-1:0][N_W-1:0]   n_nxt;
  logic [LANES-1:0]            take;
  logic                        v_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l] = (in_d[l] << (BIT+2)) + (in_den[l] << (2*BIT+2));
      diff[l]  = in_r[l] - trial[l];
      take[l]  = ~diff[l][RES_W-1];
      r_nxt[l] = take[l] ? diff[l] : in_r[l];
      d_nxt[l] = take[l] ? in_d[l] + (in_den[l] << (BIT+1)) : in_d[l];
      n_nxt[l] = in_n[l] | (N_W'(take[l]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_r    <= r_nxt;
      out_d    <= d_nxt;
      out_den  <= in_den;
      out_n    <= n_nxt;
    end
  end

  assign out_v = v_r;

endmodule

[design/nmt_checker.sv]
// ----------------------------------------------------------------------------
// Normal-map texel transform port checker
// Watches the top-level ports for stall and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "normal_map_texel_transform_macros.svh"

module nmt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input nmt_pkg::nmt_out_t out_data
);
  import nmt_pkg::*;

  `NMT_ASSERT_NOW(a_zero_clear, out_valid && out_data.zero_vector, out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
  `NMT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `NMT_ASSERT_NOW(a_stall_block, out_valid && !out_ready, !in_ready)
  `NMT_ASSERT_NOW(a_idle_ready, !out_valid || (in_valid && out_ready), in_ready)

endmodule

bind normal_map_texel_transform nmt_checker u_nmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
